@@ rtl/dcc_pkg.sv @@
// shared constants, types and the month table for the day count decoder
package dcc_pkg;

    localparam int N_STAGES = 8;

    localparam int RAW_W   = 48;
    localparam int DAYS_W  = 24;
    localparam int SECS_W  = 24;
    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 13;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    // calendar cycle lengths in days
    localparam logic [17:0] DAYS_400Y  = 18'd146097;
    localparam logic [15:0] DAYS_100Y  = 16'd36524;
    localparam logic [10:0] DAYS_4Y    = 11'd1461;
    localparam logic [8:0]  DAYS_1Y    = 9'd365;
    localparam int          QUADS_100Y = 24;

    // floor(2^24 / 146097), estimate is low by at most one
    localparam logic [6:0]  RECIP_400Y  = 7'd114;
    localparam int          RECIP_SHIFT = 24;

    localparam logic [11:0] SECS_HOUR  = 12'd3600;
    // floor(2^24 / 3600)
    localparam logic [12:0] RECIP_HOUR = 13'd4660;
    localparam logic [5:0]  SECS_MIN   = 6'd60;
    // floor(2^12 / 60)
    localparam logic [6:0]  RECIP_MIN  = 7'd68;
    localparam int          MIN_SHIFT  = 12;

    typedef logic [N_STAGES-1:0] t_stage_en;

    // day of year on which month m begins, zero based
    function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && m >= 4'd3) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

@@ rtl/datetime2_day_count_to_civil.sv @@
// top level of the timestamp decoder: handshake, stage valids and the two datapaths
//
// Decodes one 48-bit timestamp per request: bits 23..0 seconds of day, bits 47..24
// days since 0001-01-01. Gives year, month, day of month, hour, minute and second.
// Input channel i_in_valid / o_in_ready with i_raw_value; output channel
// o_out_valid / i_out_ready with the six result ports. A request moves on a
// clock edge where valid and ready are both high.
// An accepted request reaches o_out_valid through the 8 register
// stages of the date path (400 year reciprocal divide, its correction, century,
// four year and year counts, then the month table); the time path is padded to match.
// Throughput is one request per cycle while i_out_ready is high. A stage that
// holds no request always loads, so bubbles close up while the output waits.
// When the receiver holds i_out_ready low, the last stage holds its result and
// the stages behind it fill; o_in_ready drops only once all 8 stages are full.
// Synchronous active-low reset clears every stage valid; datapath registers
// are not reset. The block keeps no state between requests.
module datetime2_day_count_to_civil (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [dcc_pkg::RAW_W-1:0]    i_raw_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [dcc_pkg::YEAR_W-1:0]   o_year,
    output logic [dcc_pkg::MONTH_W-1:0]  o_month,
    output logic [dcc_pkg::DAY_W-1:0]    o_day_of_month,
    output logic [dcc_pkg::HOUR_W-1:0]   o_hour,
    output logic [dcc_pkg::MIN_W-1:0]    o_minute,
    output logic [dcc_pkg::SEC_W-1:0]    o_second
);
    import dcc_pkg::*;

    t_stage_en n_en;
    logic [N_STAGES-1:0] r_vld;

    // a stage loads when it is empty or its contents move on
    always_comb begin
        n_en[N_STAGES-1] = !r_vld[N_STAGES-1] || i_out_ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = n_en[0];
    assign o_out_valid = r_vld[N_STAGES-1];

    dcc_date u_date (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_days  (i_raw_value[SECS_W +: DAYS_W]),
        .o_year  (o_year),
        .o_month (o_month),
        .o_day   (o_day_of_month)
    );

    dcc_time u_time (
        .i_clk    (i_clk),
        .i_en     (n_en),
        .i_secs   (i_raw_value[SECS_W-1:0]),
        .o_hour   (o_hour),
        .o_minute (o_minute),
        .o_second (o_second)
    );

endmodule

@@ rtl/dcc_date.sv @@
// eight stage pipeline from day count to year, month and day
module dcc_date (
    input  logic                         i_clk,
    input  dcc_pkg::t_stage_en           i_en,
    input  logic [dcc_pkg::DAYS_W-1:0]   i_days,
    output logic [dcc_pkg::YEAR_W-1:0]   o_year,
    output logic [dcc_pkg::MONTH_W-1:0]  o_month,
    output logic [dcc_pkg::DAY_W-1:0]    o_day
);
    import dcc_pkg::*;

    // stage 0: reciprocal estimate of the 400 year count
    logic [30:0] n_s0_prod;
    logic [DAYS_W-1:0] r_s0_days;
    logic [6:0] r_s0_q;

    assign n_s0_prod = 31'(i_days) * 31'(RECIP_400Y);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s0_days <= i_days;
            r_s0_q    <= n_s0_prod[RECIP_SHIFT+6:RECIP_SHIFT];
        end
    end

    // stage 1: remainder of the estimate, below twice the days of 400 years
    logic [24:0] n_s1_rem;
    logic [18:0] r_s1_rem;
    logic [6:0]  r_s1_q;

    assign n_s1_rem = 25'(r_s0_days) - 25'(r_s0_q) * 25'(DAYS_400Y);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s1_rem <= n_s1_rem[18:0];
            r_s1_q   <= r_s0_q;
        end
    end

    // stage 2: correct the estimate
    logic        n_s2_fix;
    logic [6:0]  n_s2_q;
    logic [18:0] n_s2_rem;
    logic [17:0] r_s2_rem;
    logic [YEAR_W-1:0] r_s2_year;

    assign n_s2_fix = r_s1_rem >= 19'(DAYS_400Y);
    assign n_s2_q   = r_s1_q + 7'(n_s2_fix);
    assign n_s2_rem = n_s2_fix ? r_s1_rem - 19'(DAYS_400Y) : r_s1_rem;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s2_rem  <= n_s2_rem[17:0];
            r_s2_year <= 16'd1 + 16'(n_s2_q) * 16'd400;
        end
    end

    // stage 3: century count, clamped to three
    logic [1:0]  n_s3_q;
    logic [17:0] n_s3_rem;
    logic [15:0] r_s3_rem;
    logic [YEAR_W-1:0] r_s3_year;
    logic        r_s3_cent3;

    assign n_s3_q = 2'(r_s2_rem >= 18'(1 * int'(DAYS_100Y)))
                  + 2'(r_s2_rem >= 18'(2 * int'(DAYS_100Y)))
                  + 2'(r_s2_rem >= 18'(3 * int'(DAYS_100Y)));
    assign n_s3_rem = r_s2_rem - 18'(n_s3_q) * 18'(DAYS_100Y);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s3_rem   <= n_s3_rem[15:0];
            r_s3_year  <= r_s2_year + 16'(n_s3_q) * 16'd100;
            r_s3_cent3 <= n_s3_q == 2'd3;
        end
    end

    // stage 4: four year count by parallel compares
    logic [4:0]  n_s4_q;
    logic [4:0]  r_s4_q;
    logic [15:0] r_s4_rem;
    logic [YEAR_W-1:0] r_s4_year;
    logic        r_s4_cent3;

    always_comb begin
        n_s4_q = 5'd0;
        for (int k = 1; k <= QUADS_100Y; k++) begin
            n_s4_q = n_s4_q + 5'(r_s3_rem >= 16'(k * int'(DAYS_4Y)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s4_q     <= n_s4_q;
            r_s4_rem   <= r_s3_rem;
            r_s4_year  <= r_s3_year;
            r_s4_cent3 <= r_s3_cent3;
        end
    end

    // stage 5: remainder within the four year cycle
    logic [15:0] n_s5_rem;
    logic [10:0] r_s5_rem;
    logic [YEAR_W-1:0] r_s5_year;
    logic        r_s5_lp;

    assign n_s5_rem = r_s4_rem - 16'(r_s4_q) * 16'(DAYS_4Y);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_s5_rem  <= n_s5_rem[10:0];
            r_s5_year <= r_s4_year + 16'(r_s4_q) * 16'd4;
            // century years leap only at the end of a 400 year cycle
            r_s5_lp   <= (r_s4_q != 5'(QUADS_100Y)) || r_s4_cent3;
        end
    end

    // stage 6: year count, clamped to three, and the leap flag
    logic [1:0]  n_s6_q;
    logic [10:0] n_s6_rem;
    logic [8:0]  r_s6_rem;
    logic [YEAR_W-1:0] r_s6_year;
    logic        r_s6_leap;

    assign n_s6_q = 2'(r_s5_rem >= 11'(1 * int'(DAYS_1Y)))
                  + 2'(r_s5_rem >= 11'(2 * int'(DAYS_1Y)))
                  + 2'(r_s5_rem >= 11'(3 * int'(DAYS_1Y)));
    assign n_s6_rem = r_s5_rem - 11'(n_s6_q) * 11'(DAYS_1Y);

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_s6_rem  <= n_s6_rem[8:0];
            r_s6_year <= r_s5_year + 16'(n_s6_q);
            r_s6_leap <= (n_s6_q == 2'd3) && r_s5_lp;
        end
    end

    // stage 7: month from the table of month starts
    logic [MONTH_W-1:0] n_month;
    logic [8:0]         n_day_ofs;
    logic [YEAR_W-1:0]  r_s7_year;
    logic [MONTH_W-1:0] r_s7_month;
    logic [DAY_W-1:0]   r_s7_day;

    always_comb begin
        n_month = 4'd1;
        for (int m = 2; m <= 12; m++) begin
            if (r_s6_rem >= month_start(4'(m), r_s6_leap)) begin
                n_month = n_month + 4'd1;
            end
        end
        n_day_ofs = r_s6_rem - month_start(n_month, r_s6_leap) + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_s7_year  <= r_s6_year;
            r_s7_month <= n_month;
            r_s7_day   <= n_day_ofs[DAY_W-1:0];
        end
    end

    assign o_year  = r_s7_year;
    assign o_month = r_s7_month;
    assign o_day   = r_s7_day;

endmodule

@@ rtl/dcc_time.sv @@
// eight stage pipeline from seconds of day to hour, minute and second
module dcc_time (
    input  logic                        i_clk,
    input  dcc_pkg::t_stage_en          i_en,
    input  logic [dcc_pkg::SECS_W-1:0]  i_secs,
    output logic [dcc_pkg::HOUR_W-1:0]  o_hour,
    output logic [dcc_pkg::MIN_W-1:0]   o_minute,
    output logic [dcc_pkg::SEC_W-1:0]   o_second
);
    import dcc_pkg::*;

    // stage 0: reciprocal estimate of the hour
    logic [36:0] n_t0_prod;
    logic [SECS_W-1:0] r_t0_secs;
    logic [HOUR_W-1:0] r_t0_q;

    assign n_t0_prod = 37'(i_secs) * 37'(RECIP_HOUR);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t0_secs <= i_secs;
            r_t0_q    <= n_t0_prod[RECIP_SHIFT+HOUR_W-1:RECIP_SHIFT];
        end
    end

    // stage 1: remainder, below two hours
    logic [24:0] n_t1_rem;
    logic [12:0] r_t1_rem;
    logic [HOUR_W-1:0] r_t1_q;

    assign n_t1_rem = 25'(r_t0_secs) - 25'(r_t0_q) * 25'(SECS_HOUR);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_t1_rem <= n_t1_rem[12:0];
            r_t1_q   <= r_t0_q;
        end
    end

    // stage 2: correct the hour
    logic        n_t2_fix;
    logic [12:0] n_t2_rem;
    logic [11:0] r_t2_rem;
    logic [HOUR_W-1:0] r_t2_hour;

    assign n_t2_fix = r_t1_rem >= 13'(SECS_HOUR);
    assign n_t2_rem = n_t2_fix ? r_t1_rem - 13'(SECS_HOUR) : r_t1_rem;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_t2_rem  <= n_t2_rem[11:0];
            r_t2_hour <= r_t1_q + 13'(n_t2_fix);
        end
    end

    // stage 3: reciprocal estimate of the minute
    logic [18:0] n_t3_prod;
    logic [11:0] r_t3_rem;
    logic [MIN_W-1:0] r_t3_q;
    logic [HOUR_W-1:0] r_t3_hour;

    assign n_t3_prod = 19'(r_t2_rem) * 19'(RECIP_MIN);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_t3_rem  <= r_t2_rem;
            r_t3_q    <= n_t3_prod[MIN_SHIFT+MIN_W-1:MIN_SHIFT];
            r_t3_hour <= r_t2_hour;
        end
    end

    // stage 4: remainder, below two minutes
    logic [11:0] n_t4_rem;
    logic [6:0]  r_t4_rem;
    logic [MIN_W-1:0] r_t4_q;
    logic [HOUR_W-1:0] r_t4_hour;

    assign n_t4_rem = r_t3_rem - 12'(r_t3_q) * 12'(SECS_MIN);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_t4_rem  <= n_t4_rem[6:0];
            r_t4_q    <= r_t3_q;
            r_t4_hour <= r_t3_hour;
        end
    end

    // stage 5: correct the minute
    logic       n_t5_fix;
    logic [6:0] n_t5_sec;
    logic [HOUR_W-1:0] r_t5_hour;
    logic [MIN_W-1:0]  r_t5_min;
    logic [SEC_W-1:0]  r_t5_sec;

    assign n_t5_fix = r_t4_rem >= 7'(SECS_MIN);
    assign n_t5_sec = n_t5_fix ? r_t4_rem - 7'(SECS_MIN) : r_t4_rem;

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_t5_hour <= r_t4_hour;
            r_t5_min  <= r_t4_q + 6'(n_t5_fix);
            r_t5_sec  <= n_t5_sec[SEC_W-1:0];
        end
    end

    // stages 6 and 7: align with the date pipeline
    logic [HOUR_W-1:0] r_t6_hour, r_t7_hour;
    logic [MIN_W-1:0]  r_t6_min, r_t7_min;
    logic [SEC_W-1:0]  r_t6_sec, r_t7_sec;

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_t6_hour <= r_t5_hour;
            r_t6_min  <= r_t5_min;
            r_t6_sec  <= r_t5_sec;
        end
        if (i_en[7]) begin
            r_t7_hour <= r_t6_hour;
            r_t7_min  <= r_t6_min;
            r_t7_sec  <= r_t6_sec;
        end
    end

    assign o_hour   = r_t7_hour;
    assign o_minute = r_t7_min;
    assign o_second = r_t7_sec;

endmodule
